>>> rtl/btmx_pkg.sv
// Shared types and constants for the binary trie maximum-XOR block.
`default_nettype none

package btmx_pkg;

  localparam int unsigned KEY_BITS   = 21;
  localparam int unsigned NODE_COUNT = 4096;
  localparam int unsigned COUNT_BITS = 16;

  localparam int unsigned NODE_BITS  = $clog2(NODE_COUNT);
  localparam int unsigned FREE_BITS  = $clog2(NODE_COUNT + 1);
  localparam int unsigned LEVEL_BITS = $clog2(KEY_BITS);

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;
  localparam logic [1:0] STATUS_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [KEY_BITS-1:0] key;
  } item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] best_key;
    logic [1:0]          status;
  } result_t;

  // One branch of a node: the number of keys through it and its child link.
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [NODE_BITS-1:0]  link;
  } branch_t;

  // A node row holds both branches, indexed by the key bit.
  typedef branch_t [1:0] row_t;

  localparam int unsigned ROW_BITS = $bits(row_t);

endpackage

`default_nettype wire

>>> rtl/btmx_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module btmx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/binary_trie_max_xor.sv
// Top level of the counted binary trie with insert, remove and maximum-XOR query.
`default_nettype none

// Channel   Direction  Signals                 Transfer
// -------   ---------  ----------------------  -------------------------------
// command   in         start, busy, item_i     rising edge with start & !busy
// result    out        done_o, result_o        every cycle in which done_o is high
//
// The trie is held in one node memory, one row per node with both branches
// (count and child link). A sequencer walks the key from the top bit down,
// one trie level per clock: the registered read of the current node row
// arrives, the row is updated and written back, and the child row is read
// in the same cycle. A remove, and an insert when the pool is close to full,
// first walks the path once without writing to check it. The result appears
// on done_o in the first cycle in which busy is low again, and the next
// command may be transferred in that same cycle. Reset needs no clearing
// pass: the root row is marked unwritten and reads as zero until its first
// write, and a freshly allocated node reads as zero until the walk writes
// it. The receiver cannot stall; every result is shown for exactly one
// cycle.

module binary_trie_max_xor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire btmx_pkg::item_t   item_i,
  output logic                   done_o,
  output btmx_pkg::result_t      result_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_WALK
  } state_e;

  localparam logic [btmx_pkg::LEVEL_BITS-1:0] TopLevel =
    btmx_pkg::LEVEL_BITS'(btmx_pkg::KEY_BITS - 1);
  // While the next free node index is at most this, an insert can never run out.
  localparam logic [btmx_pkg::FREE_BITS-1:0] RoomLimit =
    btmx_pkg::FREE_BITS'(btmx_pkg::NODE_COUNT - btmx_pkg::KEY_BITS);
  localparam logic [btmx_pkg::FREE_BITS:0] PoolSize =
    (btmx_pkg::FREE_BITS + 1)'(btmx_pkg::NODE_COUNT);
  localparam logic [btmx_pkg::COUNT_BITS-1:0] CountMax = '1;

  state_e                                state_q, state_d;
  logic [1:0]                            kind_q, kind_d;
  logic [btmx_pkg::KEY_BITS-1:0]         key_q, key_d;
  logic [btmx_pkg::LEVEL_BITS-1:0]       level_q, level_d;
  logic [btmx_pkg::NODE_BITS-1:0]        node_q, node_d;
  logic                                  fresh_q, fresh_d;
  logic [btmx_pkg::KEY_BITS-1:0]         best_q, best_d;
  logic [btmx_pkg::FREE_BITS-1:0]        free_q, free_d;
  logic                                  root_valid_q, root_valid_d;
  logic                                  done_q, done_d;
  btmx_pkg::result_t                     result_q, result_d;

  logic                                  ram_we;
  logic [btmx_pkg::NODE_BITS-1:0]        rd_addr;
  logic [btmx_pkg::ROW_BITS-1:0]         ram_rdata;
  btmx_pkg::row_t                        row_rd;
  btmx_pkg::row_t                        row_new;
  logic                                  key_bit;
  logic                                  take_bit;
  logic                                  last_level;
  logic [btmx_pkg::FREE_BITS:0]          free_need;

  btmx_ram #(
    .WIDTH(btmx_pkg::ROW_BITS),
    .DEPTH(btmx_pkg::NODE_COUNT)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(node_q),
    .wdata_i(row_new),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  // The unwritten root and a node allocated this walk both read as empty.
  always_comb begin
    if (fresh_q || ((node_q == '0) && !root_valid_q)) begin
      row_rd = '0;
    end else begin
      row_rd = btmx_pkg::row_t'(ram_rdata);
    end
  end

  assign key_bit    = key_q[level_q];
  assign last_level = (level_q == '0);
  // Pool index reached if the path breaks at this level: next free plus this level and all below.
  assign free_need  = {1'b0, free_q} + (btmx_pkg::FREE_BITS + 1)'(level_q)
                      + (btmx_pkg::FREE_BITS + 1)'(1);
  // A query prefers the opposite branch whenever it holds any key.
  assign take_bit   = (row_rd[~key_bit].count != '0) ? ~key_bit : key_bit;

  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    key_d        = key_q;
    level_d      = level_q;
    node_d       = node_q;
    fresh_d      = fresh_q;
    best_d       = best_q;
    free_d       = free_q;
    root_valid_d = root_valid_q;
    done_d       = 1'b0;
    result_d     = result_q;
    ram_we       = 1'b0;
    row_new      = row_rd;
    rd_addr      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d  = item_i.kind;
          key_d   = item_i.key;
          level_d = TopLevel;
          node_d  = '0;
          fresh_d = 1'b0;
          unique case (item_i.kind)
            btmx_pkg::KIND_INSERT: begin
              state_d = (free_q <= RoomLimit) ? S_WALK : S_CHECK;
            end
            btmx_pkg::KIND_REMOVE: begin
              state_d = S_CHECK;
            end
            btmx_pkg::KIND_QUERY: begin
              state_d = S_WALK;
            end
            default: begin
              // An unused kind is answered at once and changes nothing.
              done_d            = 1'b1;
              result_d.best_key = '0;
              result_d.status   = btmx_pkg::STATUS_OK;
            end
          endcase
        end
      end

      S_CHECK: begin
        // Read-only walk that decides whether the update pass may run.
        if ((kind_q == btmx_pkg::KIND_INSERT) && (row_rd[key_bit].link == '0)) begin
          if (free_need > PoolSize) begin
            state_d           = S_IDLE;
            done_d            = 1'b1;
            result_d.best_key = '0;
            result_d.status   = btmx_pkg::STATUS_FULL;
          end else begin
            state_d = S_WALK;
            level_d = TopLevel;
            node_d  = '0;
          end
        end else if ((kind_q == btmx_pkg::KIND_REMOVE) && (row_rd[key_bit].count == '0)) begin
          state_d           = S_IDLE;
          done_d            = 1'b1;
          result_d.best_key = '0;
          result_d.status   = btmx_pkg::STATUS_ABSENT;
        end else if (last_level) begin
          state_d = S_WALK;
          level_d = TopLevel;
          node_d  = '0;
        end else begin
          level_d = level_q - 1'b1;
          node_d  = row_rd[key_bit].link;
          rd_addr = row_rd[key_bit].link;
        end
      end

      S_WALK: begin
        if (kind_q == btmx_pkg::KIND_QUERY) begin
          if ((level_q == TopLevel) && (row_rd[0].count == '0) && (row_rd[1].count == '0)) begin
            state_d           = S_IDLE;
            done_d            = 1'b1;
            result_d.best_key = '0;
            result_d.status   = btmx_pkg::STATUS_EMPTY;
          end else begin
            best_d  = {best_q[btmx_pkg::KEY_BITS-2:0], take_bit};
            level_d = level_q - 1'b1;
            node_d  = row_rd[take_bit].link;
            rd_addr = row_rd[take_bit].link;
            if (last_level) begin
              state_d           = S_IDLE;
              done_d            = 1'b1;
              result_d.best_key = {best_q[btmx_pkg::KEY_BITS-2:0], take_bit};
              result_d.status   = btmx_pkg::STATUS_OK;
            end
          end
        end else begin
          // Insert or remove: update this row and read the child row.
          ram_we  = 1'b1;
          fresh_d = 1'b0;
          if (node_q == '0) begin
            root_valid_d = 1'b1;
          end
          if (kind_q == btmx_pkg::KIND_INSERT) begin
            if (row_rd[key_bit].count != CountMax) begin
              row_new[key_bit].count = row_rd[key_bit].count + 1'b1;
            end
            if (row_rd[key_bit].link == '0) begin
              row_new[key_bit].link = free_q[btmx_pkg::NODE_BITS-1:0];
              free_d  = free_q + 1'b1;
              fresh_d = 1'b1;
            end
          end else begin
            row_new[key_bit].count = row_rd[key_bit].count - 1'b1;
          end
          level_d = level_q - 1'b1;
          node_d  = row_new[key_bit].link;
          rd_addr = row_new[key_bit].link;
          if (last_level) begin
            state_d           = S_IDLE;
            done_d            = 1'b1;
            result_d.best_key = '0;
            result_d.status   = btmx_pkg::STATUS_OK;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_q       <= btmx_pkg::FREE_BITS'(1);
      root_valid_q <= 1'b0;
      done_q       <= 1'b0;
      fresh_q      <= 1'b0;
      result_q     <= '0;
    end else begin
      state_q      <= state_d;
      free_q       <= free_d;
      root_valid_q <= root_valid_d;
      done_q       <= done_d;
      fresh_q      <= fresh_d;
      result_q     <= result_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    level_q  <= level_d;
    node_q   <= node_d;
    best_q   <= best_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

>>> verif/tb_binary_trie_max_xor.sv
// Self-checking testbench for the counted binary trie with maximum-XOR query.

module tb_binary_trie_max_xor;
  timeunit 1ns;
  timeprecision 1ps;

  // Kind 3 has no meaning in the block; it must come back as a zero result.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [btmx_pkg::KEY_BITS-1:0] KEY_MAX = '1;
  localparam logic [btmx_pkg::KEY_BITS-1:0] TOP_KEY =
    {1'b1, {(btmx_pkg::KEY_BITS-1){1'b0}}};
  localparam int unsigned SLOTS = 2 * btmx_pkg::NODE_COUNT;

  // Mirror of the trie. Each accepted command updates the mirror at once and
  // leaves the answer it must produce in a FIFO; answers are matched in order
  // because the block finishes one command before it takes the next.
  class xor_trie_scoreboard;
    bit [btmx_pkg::COUNT_BITS-1:0] branch_count [SLOTS];
    bit [btmx_pkg::NODE_BITS-1:0]  child_link [SLOTS];
    int unsigned                   next_free;
    btmx_pkg::result_t             answers_due [$];
    int unsigned inserts, refused, removes, absent, queries, empty_queries, unused;
    int unsigned errors;

    function new();
      next_free = 1;
    endfunction

    function int unsigned slot(int unsigned node, bit b);
      return (node % btmx_pkg::NODE_COUNT) * 2 + b;
    endfunction

    // Two passes: first count the nodes the path still lacks, then commit.
    function logic [1:0] insert_key(logic [btmx_pkg::KEY_BITS-1:0] key);
      int unsigned node, needed, s, fresh;
      bit missing;
      node = 0;
      needed = 0;
      missing = 1'b0;
      for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        s = slot(node, key[lvl]);
        if (missing || child_link[s] == 0) begin
          missing = 1'b1;
          needed++;
        end else begin
          node = child_link[s];
        end
      end
      if (next_free + needed > btmx_pkg::NODE_COUNT) return btmx_pkg::STATUS_FULL;
      node = 0;
      for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        s = slot(node, key[lvl]);
        if (branch_count[s] != '1) branch_count[s]++;
        if (child_link[s] == 0) begin
          fresh = next_free;
          next_free++;
          branch_count[slot(fresh, 1'b0)] = '0;
          branch_count[slot(fresh, 1'b1)] = '0;
          child_link[slot(fresh, 1'b0)] = '0;
          child_link[slot(fresh, 1'b1)] = '0;
          child_link[s] = btmx_pkg::NODE_BITS'(fresh);
        end
        node = child_link[s];
      end
      return btmx_pkg::STATUS_OK;
    endfunction

    // A zero count anywhere on the path means the key is not stored.
    function logic [1:0] remove_key(logic [btmx_pkg::KEY_BITS-1:0] key);
      int unsigned node, s;
      node = 0;
      for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        s = slot(node, key[lvl]);
        if (branch_count[s] == 0) return btmx_pkg::STATUS_ABSENT;
        node = child_link[s];
      end
      node = 0;
      for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        s = slot(node, key[lvl]);
        branch_count[s]--;
        node = child_link[s];
      end
      return btmx_pkg::STATUS_OK;
    endfunction

    // Greedy walk: take the opposite bit wherever that branch holds a key.
    function btmx_pkg::result_t best_partner(logic [btmx_pkg::KEY_BITS-1:0] key);
      btmx_pkg::result_t ans;
      int unsigned node;
      bit b;
      ans = '0;
      node = 0;
      if (branch_count[0] == 0 && branch_count[1] == 0) begin
        ans.status = btmx_pkg::STATUS_EMPTY;
        return ans;
      end
      for (int lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        b = key[lvl];
        if (branch_count[slot(node, !b)] != 0) b = !b;
        ans.best_key[lvl] = b;
        node = child_link[slot(node, b)];
      end
      return ans;
    endfunction

    function void note_command(btmx_pkg::item_t cmd);
      btmx_pkg::result_t ans;
      ans = '0;
      case (cmd.kind)
        btmx_pkg::KIND_INSERT: begin
          inserts++;
          ans.status = insert_key(cmd.key);
          if (ans.status == btmx_pkg::STATUS_FULL) refused++;
        end
        btmx_pkg::KIND_REMOVE: begin
          removes++;
          ans.status = remove_key(cmd.key);
          if (ans.status == btmx_pkg::STATUS_ABSENT) absent++;
        end
        btmx_pkg::KIND_QUERY: begin
          queries++;
          ans = best_partner(cmd.key);
          if (ans.status == btmx_pkg::STATUS_EMPTY) empty_queries++;
        end
        default: unused++;
      endcase
      answers_due.push_back(ans);
    endfunction

    function void flag(string what, logic [31:0] wanted, logic [31:0] seen);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, wanted, seen);
    endfunction

    function void check_answer(btmx_pkg::result_t got);
      btmx_pkg::result_t want;
      if (answers_due.size() == 0) begin
        flag("unrequested result", 32'hFFFF_FFFF, 32'(got));
        return;
      end
      want = answers_due.pop_front();
      if (got.best_key !== want.best_key)
        flag("best_key", 32'(want.best_key), 32'(got.best_key));
      if (got.status !== want.status)
        flag("status", 32'(want.status), 32'(got.status));
    endfunction

    function void flag_leftovers();
      while (answers_due.size() != 0)
        flag("missing result", 32'(answers_due.pop_front()), 32'hFFFF_FFFF);
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  btmx_pkg::item_t   item_i;
  logic              done_o;
  btmx_pkg::result_t result_o;

  xor_trie_scoreboard sb = new();

  // Keys that were recently inserted; removes and queries lean on them so
  // that most commands land on live paths instead of bouncing off as absent.
  logic [btmx_pkg::KEY_BITS-1:0] known_keys [$];
  int unsigned sender_idle_pct;

  binary_trie_max_xor dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The result port cannot be held off, so every strobe is checked at the
  // rising edge that ends its cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_answer(result_o);
  end

  // Drives one command from a falling edge and returns at the falling edge
  // after its transfer. A random gap before start rises lets the block sit
  // idle for a while or have start arrive anywhere inside its walk.
  task automatic send_command(input logic [1:0] kind,
                              input logic [btmx_pkg::KEY_BITS-1:0] key);
    btmx_pkg::item_t cmd;
    int unsigned gap;
    cmd.kind = kind;
    cmd.key = key;
    gap = 0;
    if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 48);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= cmd;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(cmd);
    if (kind == btmx_pkg::KIND_INSERT) begin
      known_keys.push_back(key);
      if (known_keys.size() > 64) void'(known_keys.pop_front());
    end
    @(negedge clk_i);
  endtask

  // Holds the sender back until every outstanding answer has come out.
  task automatic drain_results();
    start <= 1'b0;
    do @(negedge clk_i); while (sb.answers_due.size() != 0);
  endtask

  // Mostly keys inserted recently or close neighbours of them, so the walk
  // reuses deep paths; the rest are fresh keys and the three extreme values.
  function automatic logic [btmx_pkg::KEY_BITS-1:0] pick_key();
    int unsigned r;
    logic [btmx_pkg::KEY_BITS-1:0] base;
    r = $urandom_range(99);
    if (known_keys.size() != 0 && r < 75) begin
      base = known_keys[$urandom_range(known_keys.size() - 1)];
      if (r < 55) return base;
      return base ^ btmx_pkg::KEY_BITS'($urandom_range(1, 255));
    end
    if (r < 80) begin
      case ($urandom_range(2))
        0:       return '0;
        1:       return KEY_MAX;
        default: return TOP_KEY;
      endcase
    end
    return btmx_pkg::KEY_BITS'($urandom());
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned r;
    logic [btmx_pkg::KEY_BITS-1:0] key;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 2) drain_results();
      r = $urandom_range(99);
      if (r < 40) begin
        send_command(btmx_pkg::KIND_INSERT, pick_key());
      end else if (r < 65) begin
        // Mostly recently inserted keys; the rest come from pick_key and may miss, exercising the absent-key path.
        if (known_keys.size() != 0 && $urandom_range(99) < 70)
          key = known_keys[$urandom_range(known_keys.size() - 1)];
        else
          key = pick_key();
        send_command(btmx_pkg::KIND_REMOVE, key);
      end else if (r < 97) begin
        key = ($urandom_range(1)) ? btmx_pkg::KEY_BITS'($urandom()) : pick_key();
        send_command(btmx_pkg::KIND_QUERY, key);
      end else begin
        send_command(KIND_UNUSED, btmx_pkg::KEY_BITS'($urandom()));
      end
    end
  endtask

  // Fresh random keys each need a dozen or more new nodes, so a burst of
  // them runs the node pool dry; it stops once twelve refusals have been seen or after 600 commands.
  task automatic fill_pool();
    int unsigned refused_before;
    refused_before = sb.refused;
    for (int unsigned n = 0; n < 600 && sb.refused < refused_before + 12; n++) begin
      if ($urandom_range(9) == 0)
        send_command(btmx_pkg::KIND_QUERY, btmx_pkg::KEY_BITS'($urandom()));
      else
        send_command(btmx_pkg::KIND_INSERT, btmx_pkg::KEY_BITS'($urandom()));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    sender_idle_pct = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: empty trie, absent keys, duplicates, the extreme keys
    // and alternating bit patterns, then emptying a trie that still has nodes.
    send_command(btmx_pkg::KIND_QUERY, '0);
    send_command(btmx_pkg::KIND_REMOVE, '0);
    send_command(KIND_UNUSED, KEY_MAX);
    send_command(btmx_pkg::KIND_INSERT, '0);
    send_command(btmx_pkg::KIND_INSERT, KEY_MAX);
    send_command(btmx_pkg::KIND_INSERT, TOP_KEY);
    send_command(btmx_pkg::KIND_INSERT, KEY_MAX);
    send_command(btmx_pkg::KIND_QUERY, '0);
    send_command(btmx_pkg::KIND_QUERY, KEY_MAX);
    send_command(btmx_pkg::KIND_QUERY, TOP_KEY);
    send_command(btmx_pkg::KIND_REMOVE, KEY_MAX);
    send_command(btmx_pkg::KIND_REMOVE, KEY_MAX);
    send_command(btmx_pkg::KIND_REMOVE, KEY_MAX);
    send_command(btmx_pkg::KIND_QUERY, '0);
    send_command(btmx_pkg::KIND_REMOVE, btmx_pkg::KEY_BITS'(1));
    send_command(btmx_pkg::KIND_INSERT, btmx_pkg::KEY_BITS'(21'h0AAAAA));
    send_command(btmx_pkg::KIND_INSERT, btmx_pkg::KEY_BITS'(21'h155555));
    send_command(btmx_pkg::KIND_QUERY, btmx_pkg::KEY_BITS'(21'h155555));
    send_command(btmx_pkg::KIND_REMOVE, '0);
    send_command(btmx_pkg::KIND_REMOVE, TOP_KEY);
    send_command(btmx_pkg::KIND_REMOVE, btmx_pkg::KEY_BITS'(21'h0AAAAA));
    send_command(btmx_pkg::KIND_REMOVE, btmx_pkg::KEY_BITS'(21'h155555));
    send_command(btmx_pkg::KIND_QUERY, btmx_pkg::KEY_BITS'(21'h155555));
    send_command(KIND_UNUSED, '0);
    drain_results();

    // Random part: the sender idles often, then more often, then the pool is
    // exhausted and the last stretch runs back to back against a full pool.
    sender_idle_pct = 34;
    run_random(450);
    drain_results();
    sender_idle_pct = 51;
    run_random(450);
    drain_results();
    sender_idle_pct = 0;
    fill_pool();
    drain_results();
    run_random(400);
    start <= 1'b0;

    for (int unsigned w = 0; w < 4000 && sb.answers_due.size() != 0; w++)
      @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    sb.flag_leftovers();

    $display("Covered %0d inserts (%0d refused for lack of nodes), %0d removes (%0d absent),",
             sb.inserts, sb.refused, sb.removes, sb.absent);
    $display("%0d queries (%0d on an empty trie) and %0d commands of the unused kind.",
             sb.queries, sb.empty_queries, sb.unused);
    if (sb.errors == 0) begin
      $display("tb_binary_trie_max_xor: clean");
    end else begin
      $display("tb_binary_trie_max_xor: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #15_000_000;
    $display("tb_binary_trie_max_xor: errors");
    $finish;
  end

endmodule

>>> binary_trie_max_xor.f
rtl/btmx_pkg.sv
rtl/btmx_ram.sv
rtl/binary_trie_max_xor.sv
verif/tb_binary_trie_max_xor.sv
